// File: src/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; the front, queue, back and top-level files refer to it by scoped names.
package i2cm_pkg;

    // Command codes
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;
    localparam logic [2:0] CMD_NACK  = 3'd5;
    localparam logic [2:0] CMD_RDACK = 3'd6;
    localparam logic [2:0] CMD_PROBE = 3'd7;

    localparam int unsigned HB_WIDTH = 16;
    localparam logic [HB_WIDTH-1:0] HB_RESET = 16'd10;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

    // Bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_S0   = 5'd1,
        PH_S1   = 5'd2,
        PH_S2   = 5'd3,
        PH_P0   = 5'd4,
        PH_P1   = 5'd5,
        PH_W0   = 5'd6,
        PH_W1   = 5'd7,
        PH_W2   = 5'd8,
        PH_R0   = 5'd9,
        PH_R1   = 5'd10,
        PH_A0   = 5'd11,
        PH_N0   = 5'd12,
        PH_C1   = 5'd13,
        PH_C2   = 5'd14,
        PH_C3   = 5'd15,
        PH_K0   = 5'd16,
        PH_K1   = 5'd17,
        PH_K2   = 5'd18,
        PH_Q0   = 5'd19,
        PH_Q1   = 5'd20,
        PH_END  = 5'd21
    } phase_t;

    // One bus tick as it enters the engine
    typedef struct packed {
        logic       command_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_t;

    // Tick after classification, as held in the queue
    typedef struct packed {
        tick_t  tick;
        phase_t start_phase;
    } qitem_t;

    // One result per tick
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } result_t;

endpackage

// File: src/i2cm_ifs.sv
// Valid/ready channel interfaces of the I2C master byte engine.
// Depends on nothing; used by the front, the back and the top level.

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic       command_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output command_valid, output command,
                    output tx_byte, output sda_in, input ready);
    modport sink   (input valid, input command_valid, input command,
                    input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rx_byte, output ack_missing, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input rx_byte, input ack_missing, output ready);
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_bit_ticks;

    modport source (output valid, output half_bit_ticks, input ready);
    modport sink   (input valid, input half_bit_ticks, output ready);
endinterface

// File: src/i2cm_front.sv
// Front stage: registers each incoming tick and decodes its command into
// the sequencer's first phase. Depends on i2cm_pkg and i2cm_cmd_if.
module i2cm_front
(
    input  logic              clk,
    input  logic              rst_n,
    i2cm_cmd_if.sink          cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output i2cm_pkg::qitem_t  q_item
);

    logic              valid_reg;
    logic              valid_next;
    i2cm_pkg::qitem_t  item_reg;
    i2cm_pkg::phase_t  start_phase;
    logic              take;

    assign cmd.ready = !valid_reg || q_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        unique case (cmd.command)
            i2cm_pkg::CMD_START: start_phase = i2cm_pkg::PH_S0;
            i2cm_pkg::CMD_STOP:  start_phase = i2cm_pkg::PH_P0;
            i2cm_pkg::CMD_WRITE: start_phase = i2cm_pkg::PH_W0;
            i2cm_pkg::CMD_READ:  start_phase = i2cm_pkg::PH_R0;
            i2cm_pkg::CMD_ACK:   start_phase = i2cm_pkg::PH_A0;
            i2cm_pkg::CMD_NACK:  start_phase = i2cm_pkg::PH_N0;
            i2cm_pkg::CMD_RDACK: start_phase = i2cm_pkg::PH_K0;
            default:             start_phase = i2cm_pkg::PH_P0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (q_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.tick.command_valid <= cmd.command_valid;
            item_reg.tick.command       <= cmd.command;
            item_reg.tick.tx_byte       <= cmd.tx_byte;
            item_reg.tick.sda_in        <= cmd.sda_in;
            item_reg.start_phase        <= start_phase;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// File: src/i2cm_queue.sv
// Short FIFO between the front and back stages.
// Depends on i2cm_pkg for the entry type and depth.
module i2cm_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cm_pkg::qitem_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cm_pkg::qitem_t  out_item
);

    localparam logic [i2cm_pkg::QCNT_W-1:0] FULL = i2cm_pkg::QCNT_W'(i2cm_pkg::Q_DEPTH);
    localparam logic [i2cm_pkg::QPTR_W-1:0] LAST = i2cm_pkg::QPTR_W'(i2cm_pkg::Q_DEPTH - 1);

    i2cm_pkg::qitem_t                mem_reg [i2cm_pkg::Q_DEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [i2cm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [i2cm_pkg::QCNT_W-1:0]     count_reg;
    logic [i2cm_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [i2cm_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [i2cm_pkg::QCNT_W-1:0]     count_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + i2cm_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + i2cm_pkg::QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + i2cm_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - i2cm_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// File: src/i2cm_back.sv
// Back stage: bus sequencer that plays commands out one tick per item,
// the half-bit delay register and the result register.
// Depends on i2cm_pkg, i2cm_res_if and i2cm_cfg_if.
module i2cm_back
#(
    parameter int unsigned WAIT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  i2cm_pkg::qitem_t  q_item,
    i2cm_cfg_if.sink          cfg,
    i2cm_res_if.source        res
);

    localparam int unsigned CW = (WAIT_WIDTH > i2cm_pkg::HB_WIDTH) ? WAIT_WIDTH
                                                                  : i2cm_pkg::HB_WIDTH;
    localparam logic [CW-1:0] WAIT_MAX = CW'({WAIT_WIDTH{1'b1}});

    i2cm_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]              bit_reg, bit_next;
    logic [WAIT_WIDTH-1:0]   wait_reg, wait_next;
    logic [7:0]              shift_reg, shift_next;
    logic [2:0]              active_reg, active_next;
    logic                    scl_reg, scl_next;
    logic                    sda_reg, sda_next;
    logic                    ack_reg, ack_next;
    logic [7:0]              rx_reg, rx_next;
    logic [i2cm_pkg::HB_WIDTH-1:0] half_bit_reg;
    logic                    out_valid_reg;
    i2cm_pkg::result_t       out_reg;
    i2cm_pkg::result_t       result;
    i2cm_pkg::phase_t        cur;
    logic                    step;
    logic                    run;
    logic                    probe;
    logic                    done;
    logic [3:0]              bit_inc;
    logic [CW-1:0]           delay_ext;
    logic [WAIT_WIDTH-1:0]   delay_load;

    assign cfg.ready = 1'b1;
    assign q_ready   = !out_valid_reg || res.ready;
    assign step      = q_valid && q_ready;

    // Bus delay: zero acts as one, clamp to the counter range
    always_comb
    begin
        delay_ext = CW'(half_bit_reg);
        if (delay_ext == '0)
            delay_ext = CW'(1);
        if (delay_ext > WAIT_MAX)
            delay_ext = WAIT_MAX;
        delay_load = WAIT_WIDTH'(delay_ext - CW'(1));
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        wait_next   = wait_reg;
        shift_next  = shift_reg;
        active_next = active_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        ack_next    = ack_reg;
        rx_next     = rx_reg;
        done        = 1'b0;
        run         = 1'b0;
        cur         = phase_reg;
        bit_inc     = bit_reg + 4'd1;

        if (step)
        begin
            if (phase_reg == i2cm_pkg::PH_IDLE)
            begin
                if (q_item.tick.command_valid)
                begin
                    active_next = q_item.tick.command;
                    bit_next    = '0;
                    wait_next   = '0;
                    cur         = q_item.start_phase;
                    run         = 1'b1;
                    if (q_item.tick.command == i2cm_pkg::CMD_WRITE ||
                        q_item.tick.command == i2cm_pkg::CMD_PROBE)
                        shift_next = q_item.tick.tx_byte;
                    else if (q_item.tick.command == i2cm_pkg::CMD_READ)
                        shift_next = '0;
                end
            end
            else if (wait_reg != '0)
                wait_next = wait_reg - WAIT_WIDTH'(1);
            else
                run = 1'b1;
        end

        probe   = (active_next == i2cm_pkg::CMD_PROBE);
        bit_inc = bit_next + 4'd1;

        if (run)
        begin
            unique case (cur)
                i2cm_pkg::PH_S0:
                begin
                    sda_next = 1'b1; scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_S1;
                end
                i2cm_pkg::PH_S1:
                begin
                    sda_next = 1'b0;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_S2;
                end
                i2cm_pkg::PH_S2:
                begin
                    scl_next  = 1'b0;
                    wait_next = delay_load;
                    if (probe)
                    begin
                        bit_next   = '0;
                        phase_next = i2cm_pkg::PH_W0;
                    end
                    else
                        phase_next = i2cm_pkg::PH_END;
                end
                i2cm_pkg::PH_P0:
                begin
                    sda_next = 1'b0; scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_P1;
                end
                i2cm_pkg::PH_P1:
                begin
                    sda_next = 1'b1;
                    if (probe)
                    begin
                        // end of the leading stop runs straight into start
                        scl_next   = 1'b1;
                        wait_next  = delay_load;
                        phase_next = i2cm_pkg::PH_S1;
                    end
                    else
                    begin
                        phase_next = i2cm_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                end
                i2cm_pkg::PH_W0:
                begin
                    sda_next = shift_next[7];
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_W1;
                end
                i2cm_pkg::PH_W1:
                begin
                    scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_W2;
                end
                i2cm_pkg::PH_W2:
                begin
                    scl_next = 1'b0;
                    if (bit_next == 4'd7)
                        sda_next = 1'b1;
                    shift_next = {shift_next[6:0], 1'b0};
                    bit_next   = bit_inc;
                    wait_next  = delay_load;
                    if (!bit_inc[3])
                        phase_next = i2cm_pkg::PH_W0;
                    else if (probe)
                        phase_next = i2cm_pkg::PH_K0;
                    else
                        phase_next = i2cm_pkg::PH_END;
                end
                i2cm_pkg::PH_R0:
                begin
                    scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_R1;
                end
                i2cm_pkg::PH_R1:
                begin
                    shift_next = {shift_next[6:0], q_item.tick.sda_in};
                    scl_next   = 1'b0;
                    bit_next   = bit_inc;
                    wait_next  = delay_load;
                    phase_next = bit_inc[3] ? i2cm_pkg::PH_END : i2cm_pkg::PH_R0;
                end
                i2cm_pkg::PH_A0:
                begin
                    sda_next = 1'b0;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_C1;
                end
                i2cm_pkg::PH_N0:
                begin
                    sda_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_C1;
                end
                i2cm_pkg::PH_C1:
                begin
                    scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_C2;
                end
                i2cm_pkg::PH_C2:
                begin
                    scl_next = 1'b0;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_C3;
                end
                i2cm_pkg::PH_C3:
                begin
                    if (active_next == i2cm_pkg::CMD_ACK)
                        sda_next = 1'b1;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_K0:
                begin
                    sda_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_K1;
                end
                i2cm_pkg::PH_K1:
                begin
                    scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_K2;
                end
                i2cm_pkg::PH_K2:
                begin
                    ack_next   = q_item.tick.sda_in;
                    scl_next   = 1'b0;
                    wait_next  = delay_load;
                    phase_next = probe ? i2cm_pkg::PH_Q0 : i2cm_pkg::PH_END;
                end
                i2cm_pkg::PH_Q0:
                begin
                    sda_next = 1'b0; scl_next = 1'b1;
                    wait_next = delay_load; phase_next = i2cm_pkg::PH_Q1;
                end
                i2cm_pkg::PH_Q1:
                begin
                    sda_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                i2cm_pkg::PH_END:
                begin
                    if (active_next == i2cm_pkg::CMD_READ)
                        rx_next = shift_next;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                default:
                begin
                    phase_next = i2cm_pkg::PH_IDLE;
                end
            endcase
        end

        result.scl_out     = scl_next;
        result.sda_out     = sda_next;
        result.busy_res    = (phase_next != i2cm_pkg::PH_IDLE);
        result.done_res    = done;
        result.rx_byte     = rx_next;
        result.ack_missing = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            bit_reg       <= '0;
            wait_reg      <= '0;
            shift_reg     <= '0;
            active_reg    <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            rx_reg        <= '0;
            half_bit_reg  <= i2cm_pkg::HB_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            wait_reg   <= wait_next;
            shift_reg  <= shift_next;
            active_reg <= active_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            ack_reg    <= ack_next;
            rx_reg     <= rx_next;
            if (cfg.valid && cfg.ready)
                half_bit_reg <= cfg.half_bit_ticks;
            if (step)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_out     = out_reg.scl_out;
    assign res.sda_out     = out_reg.sda_out;
    assign res.busy_res    = out_reg.busy_res;
    assign res.done_res    = out_reg.done_res;
    assign res.rx_byte     = out_reg.rx_byte;
    assign res.ack_missing = out_reg.ack_missing;

    // Every path back to idle leaves the delay counter drained
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == i2cm_pkg::PH_IDLE |-> wait_reg == '0)
        else $error("delay counter nonzero while idle");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'd8)
        else $error("bit counter out of range");

    // A finishing tick must leave the sequencer idle on the next edge
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == i2cm_pkg::PH_IDLE)
        else $error("command finished but sequencer not idle");

    // The state only moves on a consumed tick
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(wait_reg))
        else $error("sequencer advanced without a tick");

endmodule

// File: src/i2c_master_byte_engine.sv
// I2C master byte engine: one result per tick, accepts a tick every cycle while results are taken.
// Each tick passes the front register, the queue and the result register before its result is
// valid; throughput is one tick per cycle, set by the sequencer step, unless the result channel stalls.
// Reset: asynchronous, active low; bus lines released, sequencer idle, delay = 10.
// Depends on i2cm_pkg, i2cm_ifs, i2cm_front, i2cm_queue and i2cm_back.
module i2c_master_byte_engine
#(
    parameter int unsigned WAIT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    i2cm_cmd_if.sink    cmd,
    i2cm_cfg_if.sink    cfg,
    i2cm_res_if.source  res
);

    logic              fq_valid;
    logic              fq_ready;
    i2cm_pkg::qitem_t  fq_item;
    logic              qb_valid;
    logic              qb_ready;
    i2cm_pkg::qitem_t  qb_item;

    i2cm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    i2cm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    i2cm_back #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_item  (qb_item),
        .cfg     (cfg),
        .res     (res)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the I2C master byte engine: line-level prediction per tick.
// Depends on i2cm_pkg, the channel interfaces in i2cm_ifs and the engine top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WAIT_W = 16;
    localparam longint unsigned MAX_WAIT = (64'd1 << WAIT_W) - 1;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
    } bus_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    i2cm_cmd_if cmd_bus();
    i2cm_cfg_if cfg_bus();
    i2cm_res_if res_bus();

    i2c_master_byte_engine #(.WAIT_WIDTH(WAIT_W)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .cfg   (cfg_bus),
        .res   (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted engine state
    logic [15:0]       hb_ticks = i2cm_pkg::HB_RESET;
    i2cm_pkg::phase_t  bus_phase = i2cm_pkg::PH_IDLE;
    logic [3:0]        bit_cnt = '0;
    logic [WAIT_W-1:0] hold_cnt = '0;
    logic [7:0]        shreg = '0;
    logic [2:0]        cur_cmd = i2cm_pkg::CMD_START;
    logic              scl_lvl = 1'b1;
    logic              sda_lvl = 1'b1;
    logic              ack_lvl = 1'b0;
    logic [7:0]        rx_last = '0;

    i2cm_pkg::result_t bus_expect_q[$];
    bus_op_t     plan_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          sda_force = -1;
    int unsigned cmds_taken = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;

    function automatic void hold_for(input i2cm_pkg::phase_t nxt);
        longint unsigned d;
        d = hb_ticks;
        if (d == 0) d = 1;
        if (d > MAX_WAIT) d = MAX_WAIT;
        hold_cnt = WAIT_W'(d - 1);
        bus_phase = nxt;
    endfunction

    // Run sequencer steps until one holds a delay; return 1 when the command ends.
    function automatic bit advance_bus(input logic sda);
        bit probe;
        probe = (cur_cmd == i2cm_pkg::CMD_PROBE);
        for (int g = 0; g < 4; g++)
        begin
            case (bus_phase)
                i2cm_pkg::PH_S0:
                begin
                    sda_lvl = 1'b1;
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_S1);
                    return 1'b0;
                end
                i2cm_pkg::PH_S1:
                begin
                    sda_lvl = 1'b0;
                    hold_for(i2cm_pkg::PH_S2);
                    return 1'b0;
                end
                i2cm_pkg::PH_S2:
                begin
                    scl_lvl = 1'b0;
                    if (probe)
                    begin
                        bit_cnt = '0;
                        hold_for(i2cm_pkg::PH_W0);
                    end
                    else
                        hold_for(i2cm_pkg::PH_END);
                    return 1'b0;
                end
                i2cm_pkg::PH_P0:
                begin
                    sda_lvl = 1'b0;
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_P1);
                    return 1'b0;
                end
                i2cm_pkg::PH_P1:
                begin
                    sda_lvl = 1'b1;
                    // probe goes straight on into its start on the same tick
                    if (probe)
                        bus_phase = i2cm_pkg::PH_S0;
                    else
                    begin
                        bus_phase = i2cm_pkg::PH_IDLE;
                        return 1'b1;
                    end
                end
                i2cm_pkg::PH_W0:
                begin
                    sda_lvl = shreg[7];
                    hold_for(i2cm_pkg::PH_W1);
                    return 1'b0;
                end
                i2cm_pkg::PH_W1:
                begin
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_W2);
                    return 1'b0;
                end
                i2cm_pkg::PH_W2:
                begin
                    scl_lvl = 1'b0;
                    if (bit_cnt == 4'd7) sda_lvl = 1'b1;
                    shreg = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < 4'd8)
                        hold_for(i2cm_pkg::PH_W0);
                    else
                        hold_for(probe ? i2cm_pkg::PH_K0 : i2cm_pkg::PH_END);
                    return 1'b0;
                end
                i2cm_pkg::PH_R0:
                begin
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_R1);
                    return 1'b0;
                end
                i2cm_pkg::PH_R1:
                begin
                    shreg = {shreg[6:0], sda};
                    scl_lvl = 1'b0;
                    bit_cnt = bit_cnt + 4'd1;
                    hold_for(bit_cnt < 4'd8 ? i2cm_pkg::PH_R0 : i2cm_pkg::PH_END);
                    return 1'b0;
                end
                i2cm_pkg::PH_A0:
                begin
                    sda_lvl = 1'b0;
                    hold_for(i2cm_pkg::PH_C1);
                    return 1'b0;
                end
                i2cm_pkg::PH_N0:
                begin
                    sda_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_C1);
                    return 1'b0;
                end
                i2cm_pkg::PH_C1:
                begin
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_C2);
                    return 1'b0;
                end
                i2cm_pkg::PH_C2:
                begin
                    scl_lvl = 1'b0;
                    hold_for(i2cm_pkg::PH_C3);
                    return 1'b0;
                end
                i2cm_pkg::PH_C3:
                begin
                    if (cur_cmd == i2cm_pkg::CMD_ACK) sda_lvl = 1'b1;
                    bus_phase = i2cm_pkg::PH_IDLE;
                    return 1'b1;
                end
                i2cm_pkg::PH_K0:
                begin
                    sda_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_K1);
                    return 1'b0;
                end
                i2cm_pkg::PH_K1:
                begin
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_K2);
                    return 1'b0;
                end
                i2cm_pkg::PH_K2:
                begin
                    ack_lvl = sda;
                    scl_lvl = 1'b0;
                    hold_for(probe ? i2cm_pkg::PH_Q0 : i2cm_pkg::PH_END);
                    return 1'b0;
                end
                i2cm_pkg::PH_Q0:
                begin
                    sda_lvl = 1'b0;
                    scl_lvl = 1'b1;
                    hold_for(i2cm_pkg::PH_Q1);
                    return 1'b0;
                end
                i2cm_pkg::PH_Q1:
                begin
                    sda_lvl = 1'b1;
                    bus_phase = i2cm_pkg::PH_IDLE;
                    return 1'b1;
                end
                i2cm_pkg::PH_END:
                begin
                    if (cur_cmd == i2cm_pkg::CMD_READ) rx_last = shreg;
                    bus_phase = i2cm_pkg::PH_IDLE;
                    return 1'b1;
                end
                default:
                begin
                    bus_phase = i2cm_pkg::PH_IDLE;
                    return 1'b0;
                end
            endcase
        end
        bus_phase = i2cm_pkg::PH_IDLE;
        return 1'b1;
    endfunction

    // Advance the predicted engine by one tick and return the line state it shows.
    function automatic i2cm_pkg::result_t bus_tick(input i2cm_pkg::tick_t t);
        i2cm_pkg::result_t r;
        bit fin;
        fin = 1'b0;
        if (bus_phase == i2cm_pkg::PH_IDLE)
        begin
            if (t.command_valid)
            begin
                cur_cmd = t.command;
                bit_cnt = '0;
                hold_cnt = '0;
                case (t.command)
                    i2cm_pkg::CMD_START: bus_phase = i2cm_pkg::PH_S0;
                    i2cm_pkg::CMD_STOP:  bus_phase = i2cm_pkg::PH_P0;
                    i2cm_pkg::CMD_WRITE:
                    begin
                        shreg = t.tx_byte;
                        bus_phase = i2cm_pkg::PH_W0;
                    end
                    i2cm_pkg::CMD_READ:
                    begin
                        shreg = '0;
                        bus_phase = i2cm_pkg::PH_R0;
                    end
                    i2cm_pkg::CMD_ACK:   bus_phase = i2cm_pkg::PH_A0;
                    i2cm_pkg::CMD_NACK:  bus_phase = i2cm_pkg::PH_N0;
                    i2cm_pkg::CMD_RDACK: bus_phase = i2cm_pkg::PH_K0;
                    default:
                    begin
                        shreg = t.tx_byte;
                        bus_phase = i2cm_pkg::PH_P0;
                    end
                endcase
                fin = advance_bus(t.sda_in);
            end
        end
        else if (hold_cnt != 0)
            hold_cnt = hold_cnt - 1'b1;
        else
            fin = advance_bus(t.sda_in);
        r.scl_out = scl_lvl;
        r.sda_out = sda_lvl;
        r.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
        r.done_res = fin;
        r.rx_byte = rx_last;
        r.ack_missing = ack_lvl;
        return r;
    endfunction

    function automatic logic pick_sda();
        return (sda_force < 0) ? 1'($urandom) : 1'(sda_force);
    endfunction

    function automatic void plan_add(input logic [2:0] op, input logic [7:0] data);
        bus_op_t b;
        b.op = op;
        b.data = data;
        plan_q.push_back(b);
    endfunction

    // Queue one bus transfer: mostly well-formed, sometimes a probe or a stray command.
    function automatic void plan_transfer();
        int unsigned n;
        case ($urandom_range(9))
            0: plan_add(i2cm_pkg::CMD_PROBE, 8'($urandom));
            1: plan_add(3'($urandom_range(7)), 8'($urandom));
            default:
            begin
                plan_add(i2cm_pkg::CMD_START, 8'($urandom));
                plan_add(i2cm_pkg::CMD_WRITE, 8'($urandom));
                plan_add(i2cm_pkg::CMD_RDACK, 8'($urandom));
                n = $urandom_range(3);
                repeat (n)
                begin
                    if ($urandom_range(1))
                    begin
                        plan_add(i2cm_pkg::CMD_WRITE, 8'($urandom));
                        plan_add(i2cm_pkg::CMD_RDACK, 8'($urandom));
                    end
                    else
                    begin
                        plan_add(i2cm_pkg::CMD_READ, 8'($urandom));
                        plan_add($urandom_range(1) ? i2cm_pkg::CMD_ACK : i2cm_pkg::CMD_NACK,
                                 8'($urandom));
                    end
                end
                plan_add(i2cm_pkg::CMD_STOP, 8'($urandom));
            end
        endcase
    endfunction

    function automatic i2cm_pkg::tick_t next_tick();
        i2cm_pkg::tick_t t;
        t.command = 3'($urandom_range(7));
        t.tx_byte = 8'($urandom);
        t.sda_in = pick_sda();
        t.command_valid = 1'b0;
        if (bus_phase == i2cm_pkg::PH_IDLE)
        begin
            if ($urandom_range(99) < 85)
            begin
                if (plan_q.size() == 0) plan_transfer();
                t.command = plan_q[0].op;
                t.tx_byte = plan_q[0].data;
                t.command_valid = 1'b1;
                void'(plan_q.pop_front());
            end
        end
        else
            t.command_valid = ($urandom_range(99) < 10);
        return t;
    endfunction

    // Offer one tick, wait for its handshake, then predict its result.
    task automatic send_tick(input i2cm_pkg::tick_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.command_valid <= t.command_valid;
        cmd_bus.command <= t.command;
        cmd_bus.tx_byte <= t.tx_byte;
        cmd_bus.sda_in <= t.sda_in;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        if (bus_phase == i2cm_pkg::PH_IDLE && t.command_valid) cmds_taken++;
        bus_expect_q.push_back(bus_tick(t));
        ticks_sent++;
    endtask

    // Issue one command and tick until the engine is idle again.
    task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                               input int sda_sel, input bit noise);
        i2cm_pkg::tick_t t;
        sda_force = sda_sel;
        t.command_valid = 1'b1;
        t.command = op;
        t.tx_byte = data;
        t.sda_in = pick_sda();
        send_tick(t);
        while (bus_phase != i2cm_pkg::PH_IDLE)
        begin
            t.command_valid = noise;
            t.command = 3'($urandom_range(7));
            t.tx_byte = 8'($urandom);
            t.sda_in = pick_sda();
            send_tick(t);
        end
        sda_force = -1;
    endtask

    task automatic settle_bus();
        i2cm_pkg::tick_t t;
        while (bus_phase != i2cm_pkg::PH_IDLE)
        begin
            t = next_tick();
            t.command_valid = 1'b0;
            send_tick(t);
        end
        cmd_bus.valid <= 1'b0;
        while (bus_expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_half_bit(input logic [15:0] v);
        settle_bus();
        cfg_bus.valid <= 1'b1;
        cfg_bus.half_bit_ticks <= v;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        hb_ticks = v;
    endtask

    task automatic drive_traffic(input int unsigned n_ticks);
        int unsigned base;
        base = ticks_sent;
        while (ticks_sent - base < n_ticks) send_tick(next_tick());
    endtask

    task automatic test_reset_delay();
        run_command(i2cm_pkg::CMD_START, 8'h00, -1, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 8'hFF, -1, 1'b1);
    endtask

    task automatic test_each_command();
        write_half_bit(16'd1);
        run_command(i2cm_pkg::CMD_START, 8'h3C, -1, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 8'hFF, -1, 1'b1);
        run_command(i2cm_pkg::CMD_WRITE, 8'h00, -1, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 8'hA5, -1, 1'b0);
        run_command(i2cm_pkg::CMD_RDACK, 8'h00, 0, 1'b0);
        run_command(i2cm_pkg::CMD_RDACK, 8'hFF, 1, 1'b1);
        run_command(i2cm_pkg::CMD_READ, 8'h00, 1, 1'b0);
        run_command(i2cm_pkg::CMD_ACK, 8'h00, -1, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 8'hFF, 0, 1'b1);
        run_command(i2cm_pkg::CMD_NACK, 8'h00, -1, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 8'h5A, -1, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, -1, 1'b0);
        // device answers, then no device
        run_command(i2cm_pkg::CMD_PROBE, 8'hA4, 0, 1'b1);
        run_command(i2cm_pkg::CMD_PROBE, 8'h5B, 1, 1'b0);
        run_command(i2cm_pkg::CMD_PROBE, 8'hFF, -1, 1'b0);
    endtask

    task automatic test_zero_delay();
        // a zero delay acts as one tick
        write_half_bit(16'd0);
        run_command(i2cm_pkg::CMD_START, 8'h00, -1, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), -1, 1'b1);
        run_command(i2cm_pkg::CMD_READ, 8'h00, -1, 1'b0);
        run_command(i2cm_pkg::CMD_PROBE, 8'($urandom), -1, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, -1, 1'b0);
    endtask

    task automatic test_longest_delay();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_half_bit(16'd120);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, -1, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [15:0] hb, input int unsigned n_ticks);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_half_bit(hb);
        drive_traffic(n_ticks);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        i2cm_pkg::result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            results_seen++;
            if (bus_expect_q.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_cnt++;
            end
            else
            begin
                want = bus_expect_q.pop_front();
                check_field("scl_out", want.scl_out, res_bus.scl_out);
                check_field("sda_out", want.sda_out, res_bus.sda_out);
                check_field("busy_res", want.busy_res, res_bus.busy_res);
                check_field("done_res", want.done_res, res_bus.done_res);
                check_field("rx_byte", want.rx_byte, res_bus.rx_byte);
                check_field("ack_missing", want.ack_missing, res_bus.ack_missing);
            end
        end
    end

    always @(posedge clk)
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, bus_expect_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        cmd_bus.valid = 1'b0;
        cmd_bus.command_valid = 1'b0;
        cmd_bus.command = i2cm_pkg::CMD_START;
        cmd_bus.tx_byte = '0;
        cmd_bus.sda_in = 1'b1;
        cfg_bus.valid = 1'b0;
        cfg_bus.half_bit_ticks = i2cm_pkg::HB_RESET;
        res_bus.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_delay();
        test_each_command();
        test_zero_delay();
        test_longest_delay();
        test_random_traffic(0, 0, 16'd1, 70);
        test_random_traffic(74, 0, 16'd2, 70);
        test_random_traffic(0, 74, 16'($urandom_range(1, 6)), 70);
        test_random_traffic(23, 23, 16'd3, 70);

        cmd_bus.valid <= 1'b0;
        while (bus_expect_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered %0d commands in %0d bus ticks, %0d results checked",
                 cmds_taken, ticks_sent, results_seen);
        $display("delays 0, 1, 2, 3, reset value and 120; all eight commands and probes");
        if (fail_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
src/i2cm_pkg.sv
src/i2cm_ifs.sv
src/i2cm_front.sv
src/i2cm_queue.sv
src/i2cm_back.sv
src/i2c_master_byte_engine.sv
bench/tb_top.sv
